// ===== src/modified_utf7_to_utf8_decoder_macros.svh =====
// Assertion macros for the modified UTF-7 to UTF-8 decoder.
// The macros assume a clock named clk and an active-high reset named rst in scope.
`ifndef MODIFIED_UTF7_TO_UTF8_DECODER_MACROS_SVH
`define MODIFIED_UTF7_TO_UTF8_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MU7_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MU7_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mu7_pkg.sv =====
// Shared types and constants for the modified UTF-7 to UTF-8 decoder.
// Has no dependencies; the front, queue, back and top-level files refer to it by scoped names.
`timescale 1ns / 1ps

package mu7_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  // One queued job: either a literal byte (in cp[7:0]) or a code point to encode.
  typedef struct packed {
    logic            is_lit;
    logic [CP_W-1:0] cp;
  } entry_t;

endpackage

// ===== src/mu7_front.sv =====
// Front part: accepts input bytes, tracks the shift state and builds code points.
// Depends on mu7_pkg for the queue entry type and character constants.
`timescale 1ns / 1ps

module mu7_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output mu7_pkg::entry_t   push_entry
);

  localparam logic [1:0] MODE_LIT = 2'd0;
  localparam logic [1:0] MODE_AMP = 2'd1;
  localparam logic [1:0] MODE_RUN = 2'd2;

  localparam logic [6:0] NO_SIX = 7'd64;

  logic [1:0]                mode, mode_next;
  logic [21:0]               bit_buffer, bit_buffer_next;
  logic [4:0]                bit_count, bit_count_next;
  logic [mu7_pkg::CP_W-1:0]  code_point, code_point_next;

  logic                      in_xfer;
  logic                      want_push;
  mu7_pkg::entry_t           ent;
  logic [6:0]                six;
  logic                      is_six;
  logic                      done;
  logic [1:0]                m;
  logic [21:0]               buf_sum;
  logic [4:0]                cnt_sum;
  logic [4:0]                cnt_rem;
  logic [15:0]               unit;
  logic [21:0]               shifted;

  function automatic logic [6:0] six_bits(input logic [7:0] b);
    logic [6:0] r;
    r = NO_SIX;
    case (b) inside
      [8'h41:8'h5A]: r = 7'(b - 8'h41);           // A-Z
      [8'h61:8'h7A]: r = 7'(b - 8'h61 + 8'd26);   // a-z
      [8'h30:8'h39]: r = 7'(b - 8'h30 + 8'd52);   // 0-9
      8'h2B:         r = 7'd62;                   // plus
      8'h2C:         r = 7'd63;                   // comma
      default:       r = NO_SIX;
    endcase
    return r;
  endfunction

  assign in_ready = !q_full;
  assign in_xfer  = in_valid && in_ready;
  assign push     = in_xfer && want_push;
  assign push_entry = ent;

  assign six     = six_bits(in_byte);
  assign is_six  = (six != NO_SIX);
  assign buf_sum = {bit_buffer[15:0], six[5:0]};
  assign cnt_sum = bit_count + 5'd6;
  assign cnt_rem = cnt_sum - 5'd16;
  assign shifted = buf_sum >> cnt_rem[2:0];
  assign unit    = shifted[15:0];

  always_comb begin
    mode_next       = mode;
    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    code_point_next = code_point;
    want_push       = 1'b0;
    ent.is_lit      = 1'b1;
    ent.cp          = {13'd0, in_byte};
    done            = 1'b0;
    // The unused mode code behaves as literal mode.
    m = ((mode == MODE_AMP) || (mode == MODE_RUN)) ? mode : MODE_LIT;

    if (m == MODE_AMP) begin
      if (in_byte == mu7_pkg::CHAR_DASH) begin
        want_push = 1'b1;
        ent.is_lit = 1'b1;
        ent.cp = {13'd0, mu7_pkg::CHAR_AMP};
        m = MODE_LIT;
        done = 1'b1;
      end else if (is_six) begin
        m = MODE_RUN;
      end else begin
        m = MODE_LIT;
      end
    end

    if (!done && (m == MODE_RUN)) begin
      if (is_six) begin
        done = 1'b1;
        bit_buffer_next = buf_sum;
        if (cnt_sum < 5'd16) begin
          bit_count_next = cnt_sum;
        end else begin
          bit_count_next = cnt_rem;
          if (unit[15:10] == 6'b110110) begin
            code_point_next = {1'b0, unit[9:0], 10'd0};
          end else begin
            if (unit[15:10] == 6'b110111) begin
              code_point_next = code_point + {11'd0, unit[9:0]} + 21'h10000;
            end else begin
              code_point_next = {5'd0, unit};
            end
            want_push = 1'b1;
            ent.is_lit = 1'b0;
            ent.cp = code_point_next;
          end
        end
      end else begin
        m = MODE_LIT;
        if (in_byte == mu7_pkg::CHAR_DASH) begin
          done = 1'b1;
        end
      end
    end

    if (!done) begin
      if (in_byte == mu7_pkg::CHAR_AMP) begin
        m = MODE_AMP;
        bit_buffer_next = '0;
        bit_count_next  = '0;
        code_point_next = '0;
      end else begin
        want_push = 1'b1;
        ent.is_lit = 1'b1;
        ent.cp = {13'd0, in_byte};
        m = MODE_LIT;
      end
    end

    mode_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_LIT;
      bit_buffer <= '0;
      bit_count  <= '0;
      code_point <= '0;
    end else if (in_xfer) begin
      mode       <= mode_next;
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

// ===== src/mu7_queue.sv =====
// Short register queue of pending jobs between the front and back parts.
// Depends on mu7_pkg for the entry type.
`timescale 1ns / 1ps

module mu7_queue #(
  parameter int Depth = mu7_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mu7_pkg::entry_t push_entry,
  input  logic            pop,
  output mu7_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mu7_pkg::entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CntW'(Depth));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mu7_back.sv =====
// Back part: encodes the job at the queue head as UTF-8 and sends it one byte per transfer.
// Depends on mu7_pkg for the entry type.
`timescale 1ns / 1ps

module mu7_back (
  input  logic            clk,
  input  logic            rst,
  input  mu7_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            out_valid,
  input  logic            out_ready
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic [7:0] cur_byte;
  logic       load;
  logic       at_last;

  function automatic logic [1:0] final_index(input mu7_pkg::entry_t e);
    logic [1:0] r;
    if (e.is_lit || (e.cp <= 21'h7F)) begin
      r = 2'd0;
    end else if (e.cp <= 21'h7FF) begin
      r = 2'd1;
    end else if (e.cp <= 21'hFFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input mu7_pkg::entry_t e, input logic [1:0] n,
                                           input logic [1:0] i);
    logic [7:0] r;
    r = e.cp[7:0];
    case (n)
      2'd1: r = (i == 2'd0) ? {3'b110, e.cp[10:6]} : {2'b10, e.cp[5:0]};
      2'd2: begin
        case (i)
          2'd0:    r = {4'b1110, e.cp[15:12]};
          2'd1:    r = {2'b10, e.cp[11:6]};
          default: r = {2'b10, e.cp[5:0]};
        endcase
      end
      2'd3: begin
        // The lead byte takes all three top bits, so it can reach F7.
        case (i)
          2'd0:    r = {5'b11110, e.cp[20:18]};
          2'd1:    r = {2'b10, e.cp[17:12]};
          2'd2:    r = {2'b10, e.cp[11:6]};
          default: r = {2'b10, e.cp[5:0]};
        endcase
      end
      default: r = e.cp[7:0];
    endcase
    return r;
  endfunction

  assign last_idx = final_index(head);
  assign cur_byte = utf8_byte(head, last_idx, idx);
  assign at_last  = (idx == last_idx);
  assign load     = !out_valid || out_ready;
  assign pop      = load && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte    <= cur_byte;
      last_of_run <= at_last;
    end
  end

endmodule

// ===== src/modified_utf7_to_utf8_decoder.sv =====
// Modified UTF-7 (mailbox name form) to UTF-8 decoder, top level.
// Uses mu7_pkg, mu7_front, mu7_queue, mu7_back and the assertion macro header.
//
// Input channel: in_byte with in_valid/in_ready; one modified UTF-7 byte per transfer.
// Output channel: out_byte and last_of_run with out_valid/out_ready; each input byte
// yields zero to four UTF-8 bytes, and last_of_run marks the final byte of that group.
// Bytes that produce nothing (an opening ampersand, a closing dash, a high surrogate,
// or a base64 character that does not complete a 16-bit unit) send no transfer at all.
//
// When the queue is empty, the first output byte of an input passes through the queue
// slot and then the output register. Throughput: one input byte per cycle while
// in_ready is high and one output byte per cycle while out_ready is high. The output
// port is the limit: a code point that needs several UTF-8 bytes holds the queue head
// until its last byte is loaded into the output register.
// When the receiver stalls, the output register holds its byte and the job queue
// (QueueDepth entries) keeps absorbing input; in_ready falls only when it is full.
// Reset is synchronous: it returns the decoder to literal mode, clears the shift
// state and code point, and empties the queue and output register.
`timescale 1ns / 1ps
`include "modified_utf7_to_utf8_decoder_macros.svh"

module modified_utf7_to_utf8_decoder #(
  parameter int QueueDepth = mu7_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       out_valid,
  input  logic       out_ready
);

  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;
  mu7_pkg::entry_t q_in;
  mu7_pkg::entry_t q_head;

  mu7_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  mu7_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mu7_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_valid  (!q_empty),
    .pop         (q_pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  `MU7_ASSERT_SAME(a_pop_needs_data, q_pop, !q_empty, "back part popped an empty queue")
  `MU7_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !last_of_run, out_valid, "multi-byte sequence broke off")
  `MU7_ASSERT_NEXT(a_idle_output_fills, !q_empty && !out_valid, out_valid, "queued job not moved to the output")

endmodule
